@@ sv/gtl_pkg.sv @@
// gtl_pkg: types and constants shared by the grid tile layout block.
// No dependencies.
package gtl_pkg;

    localparam int CNT_W       = 9;
    localparam int COORD_W     = 16;
    localparam int BORD_W      = 10;
    localparam int SLOT_W      = 8;
    localparam int SQ_W        = CNT_W + 2;
    localparam int PROD_W      = COORD_W + CNT_W;
    localparam int DIV_STEPS   = COORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_ADDR_W-1:0] REG_AREA_X      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_Y      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_WIDTH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_HEIGHT = 2'd3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PLACE = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_ROOT  = 8'b00000010,
        S_COLS  = 8'b00000100,
        S_LOAD  = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_FIX   = 8'b00100000,
        S_ROWS  = 8'b01000000,
        S_PLACE = 8'b10000000
    } state_t;

    // divider operand select
    typedef enum logic [1:0] {
        SEL_ROWS  = 2'd0,
        SEL_WIDTH = 2'd1,
        SEL_MAIN  = 2'd2,
        SEL_OTHER = 2'd3
    } div_sel_t;

endpackage

@@ sv/grid_tile_layout.sv @@
// grid_tile_layout: grid tiling sequencer with a shared divider and multiplier.
// Depends on gtl_pkg.
//
// channel | dir | handshake        | content
// cfg     | in  | cfg_we           | cfg_addr register index, cfg_data value
// s       | in  | s_tvalid/tready  | tuser action; tdata count, border, needs_layout
// m       | out | m_tvalid/tready  | tdata rectangle, slot index, overflow flag
//
// Start transaction: the root stepper finds isqrt(n) (n = window count), the column count
// is set, then the 16-step restoring divider makes up to four passes, with a row search
// after the first; a pass whose divisor is zero is skipped, and a zero count stays idle.
// Place transaction: a result is given from S_PLACE when needs_layout is set, else none.
// Reset clears the control and layout registers; s_tready is high only while idle.
// A result held by m_tready low stalls the next result-giving place in S_PLACE.
module grid_tile_layout #(
    parameter int MAX_WINDOWS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gtl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [gtl_pkg::COORD_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [8:0] window_count, [18:9] border, [19] needs_layout, [23:20] zero
    input  logic [gtl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] action
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] win_width, [63:48] win_height,
    // [71:64] slot_index, [72] overflow, [79:73] zero
    output logic [gtl_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import gtl_pkg::*;

    localparam logic [31:0] MAX_LIM = 32'(MAX_WINDOWS);

    state_t                 state_reg, state_next;
    div_sel_t               sel_reg, sel_next;
    logic [COORD_W-1:0]     ax_reg, ax_next, ay_reg, ay_next;
    logic [COORD_W-1:0]     aw_reg, aw_next, ah_reg, ah_next;
    logic [CNT_W-1:0]       total_reg, total_next, c_reg, c_next, r_reg, r_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [CNT_W-1:0]       other_reg, other_next, main_reg, main_next;
    logic [COORD_W-1:0]     fw_reg, fw_next, lw_reg, lw_next;
    logic [COORD_W-1:0]     h_reg [4];
    logic [COORD_W-1:0]     h_next [4];
    logic [CNT_W-1:0]       placed_reg, placed_next, row_reg, row_next, col_reg, col_next;
    logic [COORD_W-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic                   out_valid_reg, out_valid_next;

    logic [BORD_W-1:0]      border_reg, border_next;
    logic [CNT_W-1:0]       rem_reg, rem_next, dsr_reg, dsr_next;
    logic [COORD_W-1:0]     dvd_reg, dvd_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_W-1:0]     ox_reg, ox_next, oy_reg, oy_next;
    logic [COORD_W-1:0]     ow_reg, ow_next, oh_reg, oh_next;
    logic [SLOT_W-1:0]      oslot_reg, oslot_next;
    logic                   oovf_reg, oovf_next;

    logic [COORD_W-1:0]     mul_a;
    logic [CNT_W-1:0]       mul_b;
    logic [PROD_W-1:0]      prod;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_COLS:
            begin
                mul_a = COORD_W'(r_reg);
                mul_b = r_reg + 1'b1;
            end
            S_ROWS:
            begin
                mul_a = COORD_W'(other_reg);
                mul_b = c_reg - 1'b1;
            end
            S_FIX:
            begin
                mul_a = dvd_reg;
                mul_b = dsr_reg - 1'b1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        logic [CNT_W-1:0]   cnt_in;
        logic [CNT_W-1:0]   n_sat;
        logic [CNT_W:0]     shift;
        logic               qbit;
        logic [CNT_W-1:0]   main_c;
        logic [CNT_W-1:0]   row_eff;
        logic [COORD_W-1:0] cx_eff, cy_eff, wsel, hgt;
        logic [1:0]         hsel;
        logic               later;
        logic [BORD_W:0]    dbl;

        state_next     = state_reg;
        sel_next       = sel_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        aw_next        = aw_reg;
        ah_next        = ah_reg;
        total_next     = total_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        sq_next        = sq_reg;
        other_next     = other_reg;
        main_next      = main_reg;
        fw_next        = fw_reg;
        lw_next        = lw_reg;
        h_next         = h_reg;
        placed_next    = placed_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        out_valid_next = out_valid_reg && !m_tready;
        border_next    = border_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;
        oslot_next     = oslot_reg;
        oovf_next      = oovf_reg;

        cnt_in  = s_tdata[CNT_W-1:0];
        n_sat   = (32'(cnt_in) > MAX_LIM) ? CNT_W'(MAX_LIM) : cnt_in;
        shift   = {rem_reg, dvd_reg[COORD_W-1]};
        qbit    = (shift >= {1'b0, dsr_reg});
        main_c  = (prod <= PROD_W'(total_reg)) ? (total_reg - prod[CNT_W-1:0]) : '0;
        row_eff = row_reg;
        cx_eff  = cx_reg;
        cy_eff  = cy_reg;
        later   = (placed_reg >= main_reg);
        wsel    = later ? lw_reg : fw_reg;
        if (later && (col_reg == '0 || row_reg >= other_reg))
        begin
            cx_eff  = cx_reg + ((col_reg == '0) ? fw_reg : lw_reg);
            cy_eff  = ay_reg;
            row_eff = '0;
        end
        hsel = {later, row_eff != '0};
        hgt  = h_reg[hsel];
        dbl  = {border_reg, 1'b0};

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_AREA_X:      ax_next = cfg_data;
                REG_AREA_Y:      ay_next = cfg_data;
                REG_AREA_WIDTH:  aw_next = cfg_data;
                REG_AREA_HEIGHT: ah_next = cfg_data;
                default:         ax_next = ax_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_START)
                    begin
                        total_next  = n_sat;
                        placed_next = '0;
                        row_next    = '0;
                        col_next    = '0;
                        cx_next     = ax_reg;
                        cy_next     = ay_reg;
                        if (n_sat == '0)
                        begin
                            c_next     = '0;
                            main_next  = '0;
                            other_next = '0;
                            fw_next    = '0;
                            lw_next    = '0;
                            h_next     = '{default: '0};
                        end
                        else
                        begin
                            r_next     = '0;
                            sq_next    = SQ_W'(1);
                            state_next = S_ROOT;
                        end
                    end
                    else if (s_tdata[CNT_W+BORD_W])
                    begin
                        border_next = s_tdata[CNT_W+BORD_W-1:CNT_W];
                        state_next  = S_PLACE;
                    end
                end
            end
            S_ROOT:
            begin
                if (sq_reg <= SQ_W'(total_reg))
                begin
                    r_next  = r_reg + 1'b1;
                    sq_next = sq_reg + SQ_W'({r_reg, 1'b0}) + SQ_W'(3);
                end
                else
                begin
                    state_next = S_COLS;
                end
            end
            S_COLS:
            begin
                c_next     = (prod <= PROD_W'(total_reg)) ? (r_reg + 1'b1) : r_reg;
                sel_next   = SEL_ROWS;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
                case (sel_reg)
                    SEL_ROWS:
                    begin
                        dvd_next = COORD_W'(total_reg);
                        dsr_next = c_reg;
                    end
                    SEL_WIDTH:
                    begin
                        dvd_next = aw_reg;
                        dsr_next = c_reg;
                    end
                    SEL_MAIN:
                    begin
                        dvd_next = ah_reg;
                        dsr_next = main_reg;
                        if (main_reg == '0)
                        begin
                            h_next[0]  = '0;
                            h_next[1]  = '0;
                            sel_next   = SEL_OTHER;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        dvd_next = ah_reg;
                        dsr_next = other_reg;
                        if (other_reg == '0)
                        begin
                            h_next[2]  = '0;
                            h_next[3]  = '0;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                rem_next = qbit ? CNT_W'(shift - {1'b0, dsr_reg}) : shift[CNT_W-1:0];
                dvd_next = {dvd_reg[COORD_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                case (sel_reg)
                    SEL_ROWS:
                    begin
                        other_next = dvd_reg[CNT_W-1:0];
                        state_next = S_ROWS;
                    end
                    SEL_WIDTH:
                    begin
                        lw_next    = dvd_reg;
                        fw_next    = aw_reg - prod[COORD_W-1:0];
                        sel_next   = SEL_MAIN;
                        state_next = S_LOAD;
                    end
                    SEL_MAIN:
                    begin
                        h_next[1]  = dvd_reg;
                        h_next[0]  = ah_reg - prod[COORD_W-1:0];
                        sel_next   = SEL_OTHER;
                        state_next = S_LOAD;
                    end
                    default:
                    begin
                        h_next[3]  = dvd_reg;
                        h_next[2]  = ah_reg - prod[COORD_W-1:0];
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ROWS:
            begin
                if (main_c <= other_reg)
                begin
                    main_next  = main_c;
                    sel_next   = SEL_WIDTH;
                    state_next = S_LOAD;
                end
                else
                begin
                    other_next = other_reg + 1'b1;
                end
            end
            S_PLACE:
            begin
                // wait for a free output register
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    oslot_next     = placed_reg[SLOT_W-1:0];
                    if (placed_reg != CNT_MAX)
                        placed_next = placed_reg + 1'b1;
                    if (placed_reg >= total_reg)
                    begin
                        ox_next   = '0;
                        oy_next   = '0;
                        ow_next   = '0;
                        oh_next   = '0;
                        oovf_next = 1'b1;
                    end
                    else
                    begin
                        oovf_next = 1'b0;
                        ox_next   = cx_eff;
                        oy_next   = cy_eff;
                        ow_next   = (wsel > COORD_W'(dbl)) ? (wsel - COORD_W'(dbl)) : '0;
                        oh_next   = (hgt > COORD_W'(dbl)) ? (hgt - COORD_W'(dbl)) : '0;
                        cx_next   = cx_eff;
                        cy_next   = cy_eff + hgt;
                        row_next  = (row_eff != CNT_MAX) ? (row_eff + 1'b1) : row_eff;
                        if (later && (col_reg == '0 || row_reg >= other_reg)
                            && col_reg != CNT_MAX)
                            col_next = col_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_ROWS;
            ax_reg        <= '0;
            ay_reg        <= '0;
            aw_reg        <= '0;
            ah_reg        <= '0;
            total_reg     <= '0;
            c_reg         <= '0;
            r_reg         <= '0;
            sq_reg        <= '0;
            other_reg     <= '0;
            main_reg      <= '0;
            fw_reg        <= '0;
            lw_reg        <= '0;
            h_reg         <= '{default: '0};
            placed_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            aw_reg        <= aw_next;
            ah_reg        <= ah_next;
            total_reg     <= total_next;
            c_reg         <= c_next;
            r_reg         <= r_next;
            sq_reg        <= sq_next;
            other_reg     <= other_next;
            main_reg      <= main_next;
            fw_reg        <= fw_next;
            lw_reg        <= lw_next;
            h_reg         <= h_next;
            placed_reg    <= placed_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        border_reg <= border_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        dvd_reg    <= dvd_next;
        cnt_reg    <= cnt_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ow_reg     <= ow_next;
        oh_reg     <= oh_next;
        oslot_reg  <= oslot_next;
        oovf_reg   <= oovf_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, oovf_reg, oslot_reg, oh_reg, ow_reg, oy_reg, ox_reg};

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_cols_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWS) |-> (c_reg != '0))
        else $error("row search with zero columns");

    a_start_enters_root: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ACT_START && s_tdata[CNT_W-1:0] != '0)
        |=> (state_reg == S_ROOT))
        else $error("start transaction did not begin the root search");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule
